// ===== src/tlpq_pkg.sv =====
// shared types and codes for the three-level priority queue
`default_nettype none

package tlpq_pkg;

    localparam int KIND_W    = 2;
    localparam int LVL_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int PAYLOAD_W = 32;
    localparam int LEVELS    = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_GET   = 2'd1,
        KIND_ACCEL = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic [LVL_W-1:0] {
        LVL_LOW     = 2'd0,
        LVL_NORMAL  = 2'd1,
        LVL_HIGH    = 2'd2,
        LVL_INVALID = 2'd3
    } t_level;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPRI = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== src/three_level_priority_queue.sv =====
// three-level strict priority queue over a shared linked-list entry pool
`default_nettype none

// a request accepted at one clock edge shows its result, with o_valid high,
// during the following cycle; a new request is taken every cycle.
// o_busy stays low, so throughput is one request per cycle; the receiver cannot stall.
// the payload store is a memory with a registered read port.
// synchronous active-low reset empties all three levels and rebuilds the free chain at once.
module three_level_priority_queue #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [tlpq_pkg::KIND_W-1:0]         i_kind,
    input  wire logic [tlpq_pkg::LVL_W-1:0]          i_priority_req,
    input  wire logic [tlpq_pkg::PAYLOAD_W-1:0]      i_payload_in,
    output logic                                     o_valid,
    output logic [tlpq_pkg::PAYLOAD_W-1:0]           o_payload_out,
    output logic [tlpq_pkg::LVL_W-1:0]               o_served_level,
    output logic [tlpq_pkg::STATUS_W-1:0]            o_status
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // pointer state
    logic [PTR_W-1:0] r_link [CAPACITY];
    logic [PTR_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [PTR_W-1:0] r_head  [tlpq_pkg::LEVELS];
    logic [PTR_W-1:0] n_head  [tlpq_pkg::LEVELS];
    logic [PTR_W-1:0] r_tail  [tlpq_pkg::LEVELS];
    logic [PTR_W-1:0] n_tail  [tlpq_pkg::LEVELS];
    logic [CNT_W-1:0] r_count [tlpq_pkg::LEVELS];
    logic [CNT_W-1:0] n_count [tlpq_pkg::LEVELS];

    // payload store
    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_mem_q;

    // result registers
    logic                        r_valid;
    logic                        r_got;
    tlpq_pkg::t_status           r_status, n_status;
    logic [tlpq_pkg::LVL_W-1:0]  r_level, n_level;

    tlpq_pkg::t_kind             kind;
    logic                        accept;
    logic [tlpq_pkg::LVL_W-1:0]  top_lvl;
    logic                        any_full;
    logic [PTR_W-1:0]            rd_ptr;
    logic [PTR_W-1:0]            link_q;
    logic                        put_ok;
    logic                        get_ok;
    logic                        link_we;
    logic [PTR_W-1:0]            link_waddr;
    logic [PTR_W-1:0]            link_wdata;

    assign kind   = tlpq_pkg::t_kind'(i_kind);
    assign accept = i_start && !o_busy;

    // highest non-empty level
    always_comb begin
        any_full = 1'b1;
        if (r_count[2] != '0) begin
            top_lvl = tlpq_pkg::LVL_HIGH;
        end else if (r_count[1] != '0) begin
            top_lvl = tlpq_pkg::LVL_NORMAL;
        end else begin
            top_lvl  = tlpq_pkg::LVL_LOW;
            any_full = (r_count[0] != '0);
        end
    end

    // one link read per request: the free head for a put, the served head for a get
    assign rd_ptr = (kind == tlpq_pkg::KIND_PUT) ? r_free_head : r_head[top_lvl];
    assign link_q = r_link[rd_ptr];

    always_comb begin
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_status     = tlpq_pkg::ST_OK;
        n_level      = tlpq_pkg::LVL_LOW;
        put_ok       = 1'b0;
        get_ok       = 1'b0;
        link_we      = 1'b0;
        link_waddr   = r_free_head;
        link_wdata   = r_free_head;
        case (kind)
            tlpq_pkg::KIND_PUT: begin
                if (i_priority_req == tlpq_pkg::LVL_INVALID) begin
                    n_status = tlpq_pkg::ST_BADPRI;
                end else if (r_free_count == '0) begin
                    n_status = tlpq_pkg::ST_FULL;
                end else begin
                    put_ok       = 1'b1;
                    n_free_head  = link_q;
                    n_free_count = r_free_count - CNT_W'(1);
                    if (r_count[i_priority_req] == '0) begin
                        n_head[i_priority_req] = r_free_head;
                    end else begin
                        // append behind the current tail
                        link_we    = 1'b1;
                        link_waddr = r_tail[i_priority_req];
                        link_wdata = r_free_head;
                    end
                    n_tail[i_priority_req]  = r_free_head;
                    n_count[i_priority_req] = r_count[i_priority_req] + CNT_W'(1);
                end
            end
            tlpq_pkg::KIND_GET: begin
                if (!any_full) begin
                    n_status = tlpq_pkg::ST_EMPTY;
                end else begin
                    get_ok           = 1'b1;
                    n_level          = top_lvl;
                    n_count[top_lvl] = r_count[top_lvl] - CNT_W'(1);
                    if (r_count[top_lvl] == CNT_W'(1)) begin
                        n_head[top_lvl] = '0;
                        n_tail[top_lvl] = '0;
                    end else begin
                        n_head[top_lvl] = link_q;
                    end
                    // freed entry goes to the front of the free chain
                    link_we      = 1'b1;
                    link_waddr   = r_head[top_lvl];
                    link_wdata   = r_free_head;
                    n_free_head  = r_head[top_lvl];
                    n_free_count = r_free_count + CNT_W'(1);
                end
            end
            tlpq_pkg::KIND_ACCEL: begin
                if (r_count[0] != '0) begin
                    if (r_count[2] == '0) begin
                        n_head[2] = r_head[0];
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_tail[2];
                        link_wdata = r_head[0];
                    end
                    n_tail[2]  = r_tail[0];
                    n_count[2] = r_count[2] + r_count[0];
                    n_count[0] = '0;
                    n_head[0]  = '0;
                    n_tail[0]  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_link[i] <= (i == CAPACITY - 1) ? '0 : PTR_W'(i + 1);
            end
            r_free_head  <= '0;
            r_free_count <= CNT_W'(CAPACITY);
            for (int l = 0; l < tlpq_pkg::LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
            r_valid  <= 1'b0;
            r_got    <= 1'b0;
            r_status <= tlpq_pkg::ST_OK;
            r_level  <= '0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                if (link_we) begin
                    r_link[link_waddr] <= link_wdata;
                end
                r_free_head  <= n_free_head;
                r_free_count <= n_free_count;
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_got        <= get_ok;
                r_status     <= n_status;
                r_level      <= n_level;
            end
        end
    end

    // payload memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && put_ok) begin
            r_mem[r_free_head] <= DATA_WIDTH'(i_payload_in);
        end
        r_mem_q <= r_mem[r_head[top_lvl]];
    end

    assign o_busy         = 1'b0;
    assign o_valid        = r_valid;
    assign o_payload_out  = r_got ? tlpq_pkg::PAYLOAD_W'(r_mem_q) : '0;
    assign o_served_level = r_level;
    assign o_status       = r_status;

endmodule

`default_nettype wire
